// ===== hdl/wpm_pkg.sv =====
package wpm_pkg;

    // Pattern capacity and derived widths
    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_APPEND  = 2'd1;
    localparam logic [1:0] MODE_SUBJECT = 2'd2;
    localparam logic [1:0] MODE_END     = 2'd3;

    // Wildcard bytes
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // Input transaction payload
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        logic matched;
        logic error;
    } t_out;

    // Token handed from one cell to the next
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic [7:0] data;
        logic       placed;   // append byte already stored upstream
        logic       new_bit;  // updated row bit of the upstream cell
        logic       old_bit;  // row bit of the upstream cell before this token
        logic       res_bit;  // row bit of the last active cell seen so far
        logic       err;      // sticky error sampled at entry
    } t_tok;

    // Fold A-Z to a-z, leave every other byte alone
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            f = c + 8'h20;
        end
        return f;
    endfunction

endpackage

// ===== hdl/wpm_cell.sv =====
// One pattern position: holds its pattern byte, an active flag and its row bit.
module wpm_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  wpm_pkg::t_tok i_tok,
    output wpm_pkg::t_tok o_tok
);

    logic [7:0]    r_pat;
    logic          r_act;
    logic          r_bit;
    wpm_pkg::t_tok r_tok;

    logic [7:0]    n_pat;
    logic          n_act;
    logic          n_bit;
    wpm_pkg::t_tok n_tok;

    logic          w_star;
    logic          w_hit;

    assign w_star = (r_pat == wpm_pkg::STAR_BYTE);
    assign w_hit  = (r_pat == wpm_pkg::ANY_BYTE) ||
                    (wpm_pkg::fold(r_pat) == wpm_pkg::fold(i_tok.data));

    // Per-token update of this position
    always_comb begin
        n_pat = r_pat;
        n_act = r_act;
        n_bit = r_bit;
        n_tok = i_tok;
        if (i_tok.valid) begin
            unique case (i_tok.op)
                wpm_pkg::MODE_CLEAR: begin
                    n_act = 1'b0;
                    n_bit = 1'b0;
                end
                wpm_pkg::MODE_APPEND: begin
                    // first free position takes the byte
                    if (!r_act && !i_tok.placed) begin
                        n_pat        = i_tok.data;
                        n_act        = 1'b1;
                        n_bit        = (i_tok.data == wpm_pkg::STAR_BYTE) ? i_tok.old_bit : 1'b0;
                        n_tok.placed = 1'b1;
                    end
                    n_tok.old_bit = r_bit;
                end
                wpm_pkg::MODE_SUBJECT: begin
                    if (r_act) begin
                        if (w_star) begin
                            n_bit = i_tok.new_bit | r_bit;
                        end else begin
                            n_bit = w_hit ? i_tok.old_bit : 1'b0;
                        end
                        n_tok.new_bit = n_bit;
                        n_tok.old_bit = r_bit;
                    end
                end
                wpm_pkg::MODE_END: begin
                    // report, then restore the empty-subject row bit
                    if (r_act) begin
                        n_tok.res_bit = r_bit;
                        n_bit         = w_star ? i_tok.new_bit : 1'b0;
                        n_tok.new_bit = n_bit;
                    end
                end
                default: ;
            endcase
        end
    end

    // Control state and outgoing token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_bit <= 1'b0;
            r_tok <= '0;
        end else if (i_en) begin
            r_act <= n_act;
            r_bit <= n_bit;
            r_tok <= n_tok;
        end
    end

    // Pattern byte, not reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pat <= n_pat;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hdl/wildcard_pattern_matcher_top.sv =====
// Wildcard pattern matcher.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction
// per cycle while o_in_ready is high: clear pattern, append pattern byte,
// subject byte, or end of subject. Only end of subject produces an output
// transaction on o_out_valid / i_out_ready / o_out_data, carrying matched
// and the sticky error flag. Every transaction walks a row of MAX_PATTERN
// cells, one cell per cycle unless the row stalls; each cell holds one
// pattern byte and its row bit, so all cells work on different transactions.
// End of subject passes the MAX_PATTERN cell registers and then the output
// register. Throughput is one transaction per cycle while not stalled.
// The output register holds one result; while it waits, the row keeps
// moving until an end-of-subject transaction reaches the last cell, and
// only then does the whole row (and o_in_ready) stall.
// Synchronous reset empties the pattern, clears the error flag and the
// output valid flag; no clearing pass is needed.
module wildcard_pattern_matcher_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wpm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output wpm_pkg::t_out o_out_data
);

    wpm_pkg::t_tok w_tok [wpm_pkg::MAX_PATTERN+1];
    wpm_pkg::t_tok w_head;

    logic [wpm_pkg::LEN_W-1:0] r_len;
    logic                      r_pending;
    logic                      r_err;
    logic                      r_out_valid;
    wpm_pkg::t_out             r_out;

    logic w_adv;
    logic w_acc;
    logic w_drop;
    logic w_tail_end;

    // Row advance: stall only when a result reaches the tail with no room
    assign w_tail_end = w_tok[wpm_pkg::MAX_PATTERN].valid &&
                        (w_tok[wpm_pkg::MAX_PATTERN].op == wpm_pkg::MODE_END);
    assign w_adv      = !(w_tail_end && r_out_valid && !i_out_ready);
    assign o_in_ready = w_adv;
    assign w_acc      = i_in_valid && w_adv;
    assign w_drop     = (i_in_data.mode == wpm_pkg::MODE_APPEND) &&
                        (r_pending || (r_len == wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN)));

    // Head token; row bit 0 is set exactly when no subject byte is pending
    always_comb begin
        w_head.valid   = w_acc && !w_drop;
        w_head.op      = i_in_data.mode;
        w_head.data    = i_in_data.data_byte;
        w_head.placed  = 1'b0;
        w_head.new_bit = (i_in_data.mode == wpm_pkg::MODE_END);
        w_head.old_bit = !r_pending;
        w_head.res_bit = !r_pending;
        w_head.err     = r_err;
    end

    assign w_tok[0] = w_head;

    // Entry-side bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_pending <= 1'b0;
            r_err     <= 1'b0;
        end else if (w_acc) begin
            unique case (i_in_data.mode)
                wpm_pkg::MODE_CLEAR: begin
                    r_len     <= '0;
                    r_pending <= 1'b0;
                    r_err     <= 1'b0;
                end
                wpm_pkg::MODE_APPEND: begin
                    if (w_drop) begin
                        r_err <= 1'b1;
                    end else begin
                        r_len <= r_len + 1'b1;
                    end
                end
                wpm_pkg::MODE_SUBJECT: r_pending <= 1'b1;
                wpm_pkg::MODE_END:     r_pending <= 1'b0;
                default: ;
            endcase
        end
    end

    // Row of cells
    for (genvar g = 0; g < wpm_pkg::MAX_PATTERN; g++) begin : g_cell
        wpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tail_end && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail_end && w_adv) begin
            r_out.matched <= w_tok[wpm_pkg::MAX_PATTERN].res_bit;
            r_out.error   <= w_tok[wpm_pkg::MAX_PATTERN].err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_data.mode == wpm_pkg::MODE_CLEAR)
        |=> (r_len == '0) && !r_pending && !r_err)
        else $error("clear did not reset entry state");

    a_drop_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_drop |=> r_err && $stable(r_len))
        else $error("dropped append did not set error");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(w_tok[wpm_pkg::MAX_PATTERN]))
        else $error("row moved during stall");
`endif

endmodule
